### hw/rtl/tmcp_pkg.sv
// Shared constants and types for the trellis minimum-cost path block.
// Used by tmcp_ctrl, tmcp_dp and the top level; no other dependencies.
`default_nettype none
package tmcp_pkg;
  localparam int DefMaxLayers = 16;
  localparam int DefMaxLanes  = 8;
  localparam int DefCostBits  = 16;
  localparam int PathBits     = 20;
  localparam logic [PathBits-1:0] PathMax = {PathBits{1'b1}};

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_EDGE  = 2'd1,
    MODE_TERM  = 2'd2,
    MODE_RUN   = 2'd3
  } mode_t;

  // controller to datapath commands
  typedef struct packed {
    logic clr_all;    // clear terminal valid bits
    logic wipe;       // clearing pass: zero one edge word
    logic ld_edge;    // write the edge store
    logic ld_term;    // write a terminal cost
    logic init;       // seed one lane of the last layer
    logic rd;         // read one edge and its child node
    logic relax;      // apply the edge read out last cycle
    logic find;       // pick the start lane of layer 0
    logic fetch;      // read the node word for the next trace item
    logic emit;       // emit one trace item
  } tmcp_cmd_t;
endpackage
`default_nettype wire

### hw/rtl/trellis_min_cost_path.sv
// Trellis minimum-cost path: edge and terminal loads leave busy low and give no result.
// A clear keeps busy high while it zeroes every edge word, one edge word per cycle.
// A run keeps busy high while it seeds the last layer, reads one edge per cycle in the
// sweep, then emits one trace item per layer, reading each node word before its item.
// Synchronous active-low reset sets layers to 16 and runs the clearing pass.
`default_nettype none
module trellis_min_cost_path
  import tmcp_pkg::*;
#(
  parameter int MAX_LAYERS = DefMaxLayers,
  parameter int MAX_LANES  = DefMaxLanes,
  parameter int COST_BITS  = DefCostBits
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_mode,
  input  wire logic [3:0]  in_layer,
  input  wire logic [2:0]  in_from_lane,
  input  wire logic [2:0]  in_to_lane,
  input  wire logic [15:0] in_cost,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata,
  output logic             out_strobe,
  output logic [3:0]       out_path_layer,
  output logic [2:0]       out_path_lane,
  output logic [19:0]      out_path_cost,
  output logic             out_path_ok,
  output logic             out_last
);
  localparam int LyB = $clog2(MAX_LAYERS);
  localparam int LnB = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;

  tmcp_cmd_t cmd;
  logic [LyB-1:0] p, last_layer;
  logic [LnB-1:0] a, b;

  tmcp_ctrl #(.MAX_LAYERS(MAX_LAYERS), .MAX_LANES(MAX_LANES)) u_ctrl (
    .clk, .rst_n, .start, .in_mode, .cfg_we, .cfg_wdata, .busy, .cmd,
    .p_r(p), .a_r(a), .b_r(b), .last_layer
  );

  tmcp_dp #(.MAX_LAYERS(MAX_LAYERS), .MAX_LANES(MAX_LANES), .COST_BITS(COST_BITS)) u_dp (
    .clk, .rst_n, .cmd, .in_layer, .in_from_lane, .in_to_lane, .in_cost,
    .p, .a, .b, .last_layer, .out_strobe, .out_path_layer,
    .out_path_lane, .out_path_cost, .out_path_ok, .out_last
  );
endmodule
`default_nettype wire

### hw/rtl/tmcp_dp.sv
// Datapath: edge memory, terminal and node stores, saturating relax unit, tracer.
// Depends on tmcp_pkg; driven by tmcp_ctrl commands.
`default_nettype none
module tmcp_dp
  import tmcp_pkg::*;
#(
  parameter int MAX_LAYERS = DefMaxLayers,
  parameter int MAX_LANES  = DefMaxLanes,
  parameter int COST_BITS  = DefCostBits
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire tmcp_cmd_t       cmd,
  input  wire logic [3:0]      in_layer,
  input  wire logic [2:0]      in_from_lane,
  input  wire logic [2:0]      in_to_lane,
  input  wire logic [15:0]     in_cost,
  // sweep position: layer p, from lane a, to lane b
  input  wire logic [$clog2(MAX_LAYERS)-1:0] p,
  input  wire logic [((MAX_LANES > 1) ? $clog2(MAX_LANES) : 1)-1:0] a,
  input  wire logic [((MAX_LANES > 1) ? $clog2(MAX_LANES) : 1)-1:0] b,
  input  wire logic [$clog2(MAX_LAYERS)-1:0] last_layer,
  output logic                 out_strobe,
  output logic [3:0]           out_path_layer,
  output logic [2:0]           out_path_lane,
  output logic [19:0]          out_path_cost,
  output logic                 out_path_ok,
  output logic                 out_last
);
  localparam int LyB = $clog2(MAX_LAYERS);
  localparam int LnB = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
  localparam int EdB = LyB + 2*LnB;
  localparam int NdB = LyB + LnB;
  localparam int NdW = 1 + LnB + PathBits;
  localparam int NEdge = MAX_LAYERS * (2**LnB) * (2**LnB);
  localparam int NNode = MAX_LAYERS * (2**LnB);

  // edge word {valid, cost}; node word {valid, next lane, cost}
  logic [COST_BITS:0]   edge_mem [NEdge];
  logic [COST_BITS-1:0] term_mem [2**LnB];
  logic [2**LnB-1:0]    term_vld_r;
  logic [NdW-1:0]       node_mem [NNode];
  logic [2**LnB-1:0]    l0_vld_r;

  // load address; out-of-range loads are dropped
  logic ld_in_range, term_in_range;
  logic [EdB-1:0] ld_addr;
  assign ld_in_range = (32'(in_layer) < MAX_LAYERS) && (32'(in_from_lane) < MAX_LANES)
                     && (32'(in_to_lane) < MAX_LANES);
  assign term_in_range = 32'(in_from_lane) < MAX_LANES;
  assign ld_addr = {LyB'(in_layer), LnB'(in_from_lane), LnB'(in_to_lane)};

  // sweep and clearing-pass address
  logic [EdB-1:0] rd_addr;
  assign rd_addr = {p, a, b};

  // registered edge read and sweep position
  logic [COST_BITS:0] e_word_r;
  logic [NdB-1:0]     pi_r;
  logic [LnB-1:0]     bl_r;

  // edge memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wipe) edge_mem[rd_addr] <= '0;
    else if (cmd.ld_edge && ld_in_range) edge_mem[ld_addr] <= {1'b1, COST_BITS'(in_cost)};
    if (cmd.rd) begin
      e_word_r <= edge_mem[rd_addr];
      pi_r     <= {p, a};
      bl_r     <= b;
    end
  end

  // terminal store
  always_ff @(posedge clk) begin
    if (cmd.ld_term && term_in_range) term_mem[LnB'(in_from_lane)] <= COST_BITS'(in_cost);
    if (!rst_n || cmd.clr_all) term_vld_r <= '0;
    else if (cmd.ld_term && term_in_range) term_vld_r[LnB'(in_from_lane)] <= 1'b1;
  end

  // trace state
  logic [LnB-1:0] lane_r;
  logic           ok_r;
  logic [LyB-1:0] s_r;

  // node read address: child during the sweep, path node during the trace
  logic [NdB-1:0] ci, ti, node_rd_addr;
  logic [NdW-1:0] n_word_r;
  assign ci = {LyB'(p + 1'b1), b};
  assign ti = {s_r, lane_r};
  assign node_rd_addr = cmd.rd ? ci : ti;

  // saturating relax, best edge kept per parent across its to-lanes
  logic [PathBits:0]   sum;
  logic [PathBits-1:0] cand, acc_cost_r, new_cost;
  logic [LnB-1:0]      acc_nxt_r, new_nxt;
  logic                acc_vld_r, acc_vld_in, new_vld, take, node_wr;
  assign sum        = (PathBits+1)'(e_word_r[COST_BITS-1:0]) +
                      (PathBits+1)'(n_word_r[PathBits-1:0]);
  assign cand       = sum[PathBits] ? PathMax : sum[PathBits-1:0];
  assign acc_vld_in = (bl_r != '0) && acc_vld_r;
  assign take       = e_word_r[COST_BITS] && n_word_r[NdW-1]
                    && (!acc_vld_in || cand < acc_cost_r);
  assign new_vld    = take || acc_vld_in;
  assign new_cost   = take ? cand : acc_cost_r;
  assign new_nxt    = take ? bl_r : acc_nxt_r;
  assign node_wr    = cmd.relax && (bl_r == LnB'(MAX_LANES-1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= 1'b0;
    end else if (cmd.relax) begin
      acc_vld_r <= new_vld;
    end
    if (cmd.relax) begin
      acc_cost_r <= new_cost;
      acc_nxt_r  <= new_nxt;
    end
  end

  // node store: seed last layer, write each parent after its last to-lane
  always_ff @(posedge clk) begin
    if (cmd.init) node_mem[{last_layer, a}] <= {term_vld_r[a], a, PathBits'(term_mem[a])};
    else if (node_wr) node_mem[pi_r] <= {new_vld, new_nxt, new_cost};
    if (cmd.rd || cmd.fetch) n_word_r <= node_mem[node_rd_addr];
  end

  // hold layer 0 costed flags for the start lane search
  always_ff @(posedge clk) begin
    if (!rst_n) l0_vld_r <= '0;
    else if (node_wr && pi_r[NdB-1:LnB] == '0) l0_vld_r[pi_r[LnB-1:0]] <= new_vld;
  end

  // start lane search over layer 0
  logic [LnB-1:0] start_lane;
  logic           start_ok;
  always_comb begin
    start_lane = '0;
    start_ok   = 1'b0;
    for (int i = MAX_LANES-1; i >= 0; i--) begin
      if (l0_vld_r[i]) begin
        start_ok   = 1'b1;
        start_lane = LnB'(i);
      end
    end
  end

  logic                ok_now;
  logic [LnB-1:0]      t_nxt;
  logic [PathBits-1:0] t_cost;
  assign ok_now = ok_r && n_word_r[NdW-1];
  assign t_nxt  = n_word_r[PathBits +: LnB];
  assign t_cost = n_word_r[PathBits-1:0];

  // forward trace and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
      ok_r       <= 1'b0;
      lane_r     <= '0;
      s_r        <= '0;
    end else begin
      out_strobe <= cmd.emit;
      if (cmd.find) begin
        ok_r   <= start_ok;
        lane_r <= start_lane;
        s_r    <= '0;
      end else if (cmd.emit) begin
        ok_r   <= ok_now;
        lane_r <= ok_now ? t_nxt : '0;
        s_r    <= s_r + 1'b1;
      end
    end
    if (cmd.emit) begin
      out_path_layer <= 4'(s_r);
      out_path_lane  <= ok_now ? 3'(lane_r) : 3'd0;
      out_path_cost  <= ok_now ? t_cost : '0;
      out_path_ok    <= ok_now;
      out_last       <= (s_r == last_layer);
    end
  end
endmodule
`default_nettype wire

### hw/rtl/tmcp_ctrl.sv
// Controller: decodes transactions and sequences the sweep and trace.
// Depends on tmcp_pkg; drives tmcp_dp.
`default_nettype none
module tmcp_ctrl
  import tmcp_pkg::*;
#(
  parameter int MAX_LAYERS = DefMaxLayers,
  parameter int MAX_LANES  = DefMaxLanes
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] in_mode,
  input  wire logic       cfg_we,
  input  wire logic [4:0] cfg_wdata,
  output logic            busy,
  output tmcp_cmd_t       cmd,
  output logic [$clog2(MAX_LAYERS)-1:0] p_r,
  output logic [((MAX_LANES > 1) ? $clog2(MAX_LANES) : 1)-1:0] a_r,
  output logic [((MAX_LANES > 1) ? $clog2(MAX_LANES) : 1)-1:0] b_r,
  output logic [$clog2(MAX_LAYERS)-1:0] last_layer
);
  localparam int LyB = $clog2(MAX_LAYERS);
  localparam int LnB = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_INIT, S_SWEEP, S_DRAIN, S_FIND, S_READ, S_EMIT
  } state_t;

  state_t         state_r;
  logic [4:0]     layers_r;
  logic [LyB-1:0] s_r;
  logic           relax_r;
  logic           go, b_wrap, a_wrap, p_zero;

  // clamp layer count to 2..MAX_LAYERS
  always_comb begin
    if (layers_r < 5'd2) last_layer = LyB'(1);
    else if (32'(layers_r) > MAX_LAYERS) last_layer = LyB'(MAX_LAYERS-1);
    else last_layer = LyB'(layers_r - 5'd1);
  end

  assign go     = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign b_wrap = (b_r == LnB'(MAX_LANES-1));
  assign a_wrap = (a_r == LnB'(MAX_LANES-1));
  assign p_zero = (p_r == '0);

  always_comb begin
    cmd         = '0;
    cmd.clr_all = go && (mode_t'(in_mode) == MODE_CLEAR);
    cmd.ld_edge = go && (mode_t'(in_mode) == MODE_EDGE);
    cmd.ld_term = go && (mode_t'(in_mode) == MODE_TERM);
    cmd.wipe    = (state_r == S_CLEAR);
    cmd.init    = (state_r == S_INIT);
    cmd.rd      = (state_r == S_SWEEP);
    cmd.relax   = relax_r;
    cmd.find    = (state_r == S_FIND);
    cmd.fetch   = (state_r == S_READ);
    cmd.emit    = (state_r == S_EMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      layers_r <= 5'd16;
      p_r      <= LyB'(MAX_LAYERS-1);
      a_r      <= '0;
      b_r      <= '0;
      s_r      <= '0;
      relax_r  <= 1'b0;
    end else begin
      if (cfg_we) layers_r <= cfg_wdata;
      // relax in the cycle after each edge read
      relax_r <= (state_r == S_SWEEP);
      unique case (state_r)
        S_IDLE: begin
          if (go && mode_t'(in_mode) == MODE_CLEAR) begin
            p_r     <= LyB'(MAX_LAYERS-1);
            a_r     <= '0;
            b_r     <= '0;
            state_r <= S_CLEAR;
          end else if (go && mode_t'(in_mode) == MODE_RUN) begin
            a_r     <= '0;
            state_r <= S_INIT;
          end
        end
        S_INIT: begin
          // seed one last-layer lane per cycle
          if (a_wrap) begin
            a_r     <= '0;
            b_r     <= '0;
            p_r     <= last_layer - 1'b1;
            state_r <= S_SWEEP;
          end else begin
            a_r <= a_r + 1'b1;
          end
        end
        S_CLEAR, S_SWEEP: begin
          // advance to-lane, then from-lane, then layer downward
          if (b_wrap) begin
            b_r <= '0;
            if (a_wrap) begin
              a_r <= '0;
              if (p_zero) state_r <= (state_r == S_CLEAR) ? S_IDLE : S_DRAIN;
              else p_r <= p_r - 1'b1;
            end else begin
              a_r <= a_r + 1'b1;
            end
          end else begin
            b_r <= b_r + 1'b1;
          end
        end
        S_DRAIN: state_r <= S_FIND;
        S_FIND: begin
          s_r     <= '0;
          state_r <= S_READ;
        end
        S_READ: state_r <= S_EMIT;
        S_EMIT: begin
          s_r <= s_r + 1'b1;
          if (s_r == last_layer) state_r <= S_IDLE;
          else state_r <= S_READ;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
